>>> rtl/fxalu_pkg.sv
// Package for the Q24.8 fixed-point arithmetic unit: opcodes, status codes,
// widths and the beat type that travels down the divider chain.
// Depends on nothing.
`default_nettype none
package fxalu_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int W             = 32;
    localparam int NUM_W         = W + FRACTION_BITS;
    localparam int DIV_STEPS     = NUM_W;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
        OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
        OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic               valid;
        logic               is_div;
        logic               neg;
        logic               div0;
        logic [NUM_W-1:0]   num;
        logic [W-1:0]       den;
        logic [W:0]         rem;
        logic [NUM_W-1:0]   quo;
        logic [W-1:0]       result;
        logic               cmp;
        logic [1:0]         status;
    } beat_t;

endpackage
`default_nettype wire

>>> rtl/fxalu_cell.sv
// One restoring-division cell: takes one quotient bit per cycle while en
// is high and passes the beat on. Depends on fxalu_pkg.
`default_nettype none
module fxalu_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire fxalu_pkg::beat_t beat_in,
    output fxalu_pkg::beat_t      beat_out
);

    fxalu_pkg::beat_t beat_reg;
    fxalu_pkg::beat_t beat_next;
    logic [fxalu_pkg::W+1:0] trial;
    logic [fxalu_pkg::W:0]   shifted;

    always_comb begin
        beat_next = beat_in;
        shifted   = {beat_in.rem[fxalu_pkg::W-1:0], beat_in.num[fxalu_pkg::NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b00, beat_in.den};
        beat_next.num = {beat_in.num[fxalu_pkg::NUM_W-2:0], 1'b0};
        if (!trial[fxalu_pkg::W+1]) begin
            beat_next.rem = trial[fxalu_pkg::W:0];
            beat_next.quo = {beat_in.quo[fxalu_pkg::NUM_W-2:0], 1'b1};
        end else begin
            beat_next.rem = shifted;
            beat_next.quo = {beat_in.quo[fxalu_pkg::NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule
`default_nettype wire

>>> rtl/fxalu_front.sv
// Front stage: decodes the opcode, computes all results but divide and
// multiply, forms the product and loads the divider beat. Needs fxalu_pkg.
`default_nettype none
module fxalu_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [3:0]        op,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output fxalu_pkg::beat_t       beat_out,
    output logic                   mul_valid,
    output logic [63:0]            mul_prod
);

    localparam int F = fxalu_pkg::FRACTION_BITS;

    fxalu_pkg::beat_t beat_reg;
    fxalu_pkg::beat_t beat_next;
    logic        mvalid_reg;
    logic [63:0] mprod_reg;
    logic [31:0] amag, bmag;
    logic signed [32:0] sum33, dif33;
    logic signed [63:0] fi;
    logic [31:0] r;
    logic [1:0]  st;
    logic        c;

    always_comb begin
        amag  = a[31] ? (32'd0 - a) : a;
        bmag  = b[31] ? (32'd0 - b) : b;
        sum33 = {a[31], a} + {b[31], b};
        dif33 = {a[31], a} - {b[31], b};
        fi    = 64'(a) <<< F;
        r  = '0;
        st = fxalu_pkg::ST_OK;
        c  = 1'b0;
        case (fxalu_pkg::op_t'(op))
            fxalu_pkg::OP_ADD: begin
                r = sum33[31:0];
                if (sum33[32] != sum33[31]) begin
                    r  = sum33[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                    st = fxalu_pkg::ST_SAT;
                end
            end
            fxalu_pkg::OP_SUB: begin
                r = dif33[31:0];
                if (dif33[32] != dif33[31]) begin
                    r  = dif33[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                    st = fxalu_pkg::ST_SAT;
                end
            end
            fxalu_pkg::OP_GT: c = a > b;
            fxalu_pkg::OP_LT: c = a < b;
            fxalu_pkg::OP_GE: c = a >= b;
            fxalu_pkg::OP_LE: c = a <= b;
            fxalu_pkg::OP_EQ: c = a == b;
            fxalu_pkg::OP_NE: c = a != b;
            fxalu_pkg::OP_INC: begin
                r = a + 32'sd1;
                if (a == 32'sh7fff_ffff) begin
                    r  = a;
                    st = fxalu_pkg::ST_SAT;
                end
            end
            fxalu_pkg::OP_DEC: begin
                r = a - 32'sd1;
                if (a == 32'sh8000_0000) begin
                    r  = a;
                    st = fxalu_pkg::ST_SAT;
                end
            end
            fxalu_pkg::OP_MIN: r = (a < b) ? a : b;
            fxalu_pkg::OP_MAX: r = (a > b) ? a : b;
            fxalu_pkg::OP_TOINT: r = 32'(a >>> F);
            fxalu_pkg::OP_FROMINT: begin
                r = fi[31:0];
                if (fi > 64'sh7fff_ffff) begin
                    r  = 32'h7fff_ffff;
                    st = fxalu_pkg::ST_SAT;
                end else if (fi < -64'sh8000_0000) begin
                    r  = 32'h8000_0000;
                    st = fxalu_pkg::ST_SAT;
                end
            end
            fxalu_pkg::OP_DIV: begin
                if (b == 32'sd0) st = fxalu_pkg::ST_DIV0;
            end
            default: r = '0;
        endcase
        beat_next        = '0;
        beat_next.valid  = in_valid;
        beat_next.is_div = (op == fxalu_pkg::OP_DIV) || (op == fxalu_pkg::OP_MUL);
        beat_next.neg    = a[31] ^ b[31];
        beat_next.div0   = (op == fxalu_pkg::OP_DIV) && (b == 32'sd0);
        beat_next.num    = {amag, {F{1'b0}}};
        beat_next.den    = bmag;
        beat_next.result = r;
        beat_next.cmp    = c;
        beat_next.status = st;
        if (op == fxalu_pkg::OP_MUL) beat_next.num = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
            mvalid_reg     <= 1'b0;
        end else if (en) begin
            beat_reg   <= beat_next;
            mvalid_reg <= in_valid && (op == fxalu_pkg::OP_MUL);
            mprod_reg  <= amag * bmag;
        end
    end

    assign beat_out  = beat_reg;
    assign mul_valid = mvalid_reg;
    assign mul_prod  = mprod_reg;

endmodule
`default_nettype wire

>>> rtl/fxalu_back.sv
// Back stage: rounds and saturates divider and multiplier results and holds
// the result beat. Depends on fxalu_pkg.
`default_nettype none
module fxalu_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire fxalu_pkg::beat_t  beat_in,
    input  wire logic              is_mul,
    input  wire logic [63:0]       prod,
    output logic                   valid,
    output logic [31:0]            result,
    output logic                   cmp,
    output logic [1:0]             status
);

    localparam int F  = fxalu_pkg::FRACTION_BITS;
    localparam int NW = fxalu_pkg::NUM_W;

    logic          valid_reg;
    logic [31:0]   result_reg;
    logic          cmp_reg;
    logic [1:0]    status_reg;
    logic [NW:0]   q;
    logic [63:0]   mq;
    logic [64:0]   mag;
    logic [32:0]   den1, rem2;
    logic [31:0]   r;
    logic [1:0]    st;

    always_comb begin
        den1 = {1'b0, beat_in.den};
        rem2 = {beat_in.rem[31:0], 1'b0};
        q    = {1'b0, beat_in.quo} + {{NW{1'b0}}, (rem2 >= den1)};
        mq   = (prod + (64'd1 << (F - 1))) >> F;
        mag  = is_mul ? {1'b0, mq} : 65'(q);
        r    = beat_in.result;
        st   = beat_in.status;
        if (beat_in.is_div && !beat_in.div0) begin
            if (mag > 65'h8000_0000 || (mag == 65'h8000_0000 && !beat_in.neg)) begin
                r  = beat_in.neg ? 32'h8000_0000 : 32'h7fff_ffff;
                st = fxalu_pkg::ST_SAT;
            end else begin
                r = beat_in.neg ? (32'd0 - mag[31:0]) : mag[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg  <= beat_in.valid;
            result_reg <= r;
            cmp_reg    <= beat_in.cmp;
            status_reg <= st;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;
    assign cmp    = cmp_reg;
    assign status = status_reg;

endmodule
`default_nettype wire

>>> rtl/fixed_point_alu_q24_8.sv
// Top level of the Q24.8 fixed-point arithmetic unit.
// Depends on fxalu_pkg, fxalu_front, fxalu_cell and fxalu_back.
//
// Every operation takes the same path: a front stage, a chain of forty
// division cells that each settle one quotient bit, and a back stage that
// rounds and saturates. A new beat may be accepted in every cycle in which
// the pipeline is not halted. The whole pipeline advances together and halts
// while the result beat waits to be taken. Multiply products ride a parallel
// delay line alongside the division chain.
`default_nettype none
module fixed_point_alu_q24_8 (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_op,
    input  wire logic signed [31:0] s_operand_a,
    input  wire logic signed [31:0] s_operand_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_result_raw,
    output logic                    m_compare_true,
    output logic [1:0]              m_status
);

    localparam int N = fxalu_pkg::DIV_STEPS;

    logic en;
    fxalu_pkg::beat_t chain [N+1];
    logic        mv_reg [N+1];
    logic [63:0] mp_reg [N+1];
    logic [31:0] res;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    fxalu_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid && en),
        .op(s_op), .a(s_operand_a), .b(s_operand_b),
        .beat_out(chain[0]), .mul_valid(mv_reg[0]), .mul_prod(mp_reg[0])
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        fxalu_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .beat_in(chain[i]), .beat_out(chain[i+1])
        );
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mv_reg[i+1] <= 1'b0;
            end else if (en) begin
                mv_reg[i+1] <= mv_reg[i];
                mp_reg[i+1] <= mp_reg[i];
            end
        end
    end

    fxalu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .en(en), .beat_in(chain[N]),
        .is_mul(mv_reg[N]), .prod(mp_reg[N]),
        .valid(m_valid), .result(res), .cmp(m_compare_true), .status(m_status)
    );

    assign m_result_raw = res;

endmodule
`default_nettype wire
